// File: rtl/unique_label_collector_macros.svh
// Assertion macros for the unique label collector.
`ifndef UNIQUE_LABEL_COLLECTOR_MACROS_SVH
`define UNIQUE_LABEL_COLLECTOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, clocked on clk_i, off while in reset
`define ULC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("unique_label_collector: same-cycle check failed");
// Next-cycle implication, clocked on clk_i, off while in reset
`define ULC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("unique_label_collector: next-cycle check failed");
`else
`define ULC_ASSERT_IMP(lbl, ante, cons)
`define ULC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/ulc_pkg.sv
// Shared types and constants of the unique label collector.
`default_nettype none

package ulc_pkg;

  // Bitmap word geometry
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_IDX_W = 5;

  // Beat operation codes (carried in tuser)
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_FETCH  = 1'b1;

  // Background handling codes
  localparam logic INCL_BG = 1'b1;
  localparam logic EXCL_BG = 1'b0;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_REC   = 4'b0100,
    S_SCAN  = 4'b1000
  } state_e;

  // Word unit function
  typedef enum logic {
    WU_SET  = 1'b0,
    WU_FIND = 1'b1
  } wu_mode_e;

  // Control into the word unit
  typedef struct packed {
    wu_mode_e               mode;
    logic                   clr_bit0;
    logic [BIT_IDX_W-1:0]   bit_idx;
  } wu_ctrl_t;

  // Status out of the word unit
  typedef struct packed {
    logic                   nonzero;
    logic [BIT_IDX_W-1:0]   bit_idx;
  } wu_stat_t;

endpackage

`default_nettype wire

// File: rtl/ulc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ulc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/ulc_word_unit.sv
// Shared word unit: sets a bit, or finds and clears the lowest set bit.
`default_nettype none

module ulc_word_unit (
  input  wire logic [ulc_pkg::WORD_BITS-1:0] rdata_i,
  input  wire ulc_pkg::wu_ctrl_t             ctrl_i,
  output logic      [ulc_pkg::WORD_BITS-1:0] word_o,
  output ulc_pkg::wu_stat_t                  stat_o
);

  logic [ulc_pkg::WORD_BITS-1:0] eff;
  logic [ulc_pkg::WORD_BITS-1:0] low;
  logic [ulc_pkg::BIT_IDX_W-1:0] idx;

  // Word as seen by a search; background bit dropped when excluded
  always_comb begin
    eff = rdata_i;
    if (ctrl_i.clr_bit0) begin
      eff[0] = 1'b0;
    end
  end

  // Isolate the lowest set bit
  assign low = eff & (~eff + ulc_pkg::WORD_BITS'(1));

  // Encode the one-hot lowest bit
  always_comb begin
    idx = '0;
    for (int j = 0; j < ulc_pkg::WORD_BITS; j++) begin
      if (low[j]) begin
        idx = idx | ulc_pkg::BIT_IDX_W'(j);
      end
    end
  end

  // New word and status
  always_comb begin
    stat_o.nonzero = |eff;
    stat_o.bit_idx = idx;
    case (ctrl_i.mode)
      ulc_pkg::WU_SET:  word_o = rdata_i | (ulc_pkg::WORD_BITS'(1) << ctrl_i.bit_idx);
      ulc_pkg::WU_FIND: word_o = eff & ~low;
      default:          word_o = rdata_i;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/unique_label_collector.sv
// An unmasked record beat has no effect; a masked one reads its word, then writes it back.
// A fetch scans bitmap words upward from the cursor, one word per cycle on the single
// bitmap RAM port pair, and stalls on its final word until the output slot is free.
// The result sits in an output register; the next beat is taken while it waits.
// Reset: a clearing pass writes all 2^(LABEL_BITS-5) words (2048 at 16 bits), one per cycle,
// with no input beat taken; cursor clears to 0 and background is excluded.
`default_nettype none

`include "unique_label_collector_macros.svh"

module unique_label_collector #(
  parameter int unsigned LABEL_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: include_background
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [15:0] pixel_label, [16] in_mask, rest zero
  input  wire logic        s_axis_tuser,  // [0] operation
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // [15:0] found_label
  output logic             m_axis_tuser   // [0] found
);

  localparam int unsigned MAP_AW    = LABEL_BITS - 5;
  localparam int unsigned MAP_WORDS = 2 ** MAP_AW;

  ulc_pkg::state_e state_q, state_d;

  logic [MAP_AW-1:0]             clr_q, clr_d;
  logic [MAP_AW-1:0]             scan_q, scan_d;
  logic [MAP_AW-1:0]             cursor_q, cursor_d;
  logic [MAP_AW-1:0]             rec_word_q, rec_word_d;
  logic [ulc_pkg::BIT_IDX_W-1:0] rec_bit_q, rec_bit_d;
  logic                          incl_q;

  logic        out_valid_q, out_valid_d;
  logic [15:0] out_label_q, out_label_d;
  logic        out_found_q, out_found_d;
  logic        out_load;

  logic [LABEL_BITS-1:0]         lab;
  logic [MAP_AW-1:0]             in_word;
  logic [ulc_pkg::BIT_IDX_W-1:0] in_bit;
  logic                          in_op;
  logic                          in_mask;
  logic                          in_acc;
  logic                          slot_free;

  logic                          ram_we;
  logic [MAP_AW-1:0]             ram_waddr;
  logic [MAP_AW-1:0]             ram_raddr;
  logic [ulc_pkg::WORD_BITS-1:0] ram_wdata;
  logic [ulc_pkg::WORD_BITS-1:0] ram_rdata;

  ulc_pkg::wu_ctrl_t             wu_ctrl;
  ulc_pkg::wu_stat_t             wu_stat;
  logic [ulc_pkg::WORD_BITS-1:0] wu_word;

  // Beat decode
  assign lab     = LABEL_BITS'(s_axis_tdata[15:0]);
  assign in_word = lab[LABEL_BITS-1:5];
  assign in_bit  = lab[4:0];
  assign in_op   = s_axis_tuser;
  assign in_mask = s_axis_tdata[16];

  assign s_axis_tready = (state_q == ulc_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;

  // Presence bitmap
  ulc_ram #(
    .WIDTH (ulc_pkg::WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Word unit control
  always_comb begin
    wu_ctrl.mode     = (state_q == ulc_pkg::S_REC) ? ulc_pkg::WU_SET : ulc_pkg::WU_FIND;
    wu_ctrl.clr_bit0 = (scan_q == '0) && (incl_q == ulc_pkg::EXCL_BG);
    wu_ctrl.bit_idx  = rec_bit_q;
  end

  ulc_word_unit u_word (
    .rdata_i (ram_rdata),
    .ctrl_i  (wu_ctrl),
    .word_o  (wu_word),
    .stat_o  (wu_stat)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    cursor_d    = cursor_q;
    rec_word_d  = rec_word_q;
    rec_bit_d   = rec_bit_q;
    ram_we      = 1'b0;
    ram_waddr   = scan_q;
    ram_wdata   = wu_word;
    ram_raddr   = scan_q;
    out_load    = 1'b0;
    out_label_d = out_label_q;
    out_found_d = out_found_q;

    unique case (state_q)
      ulc_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + MAP_AW'(1);
        if (&clr_q) begin
          state_d = ulc_pkg::S_IDLE;
        end
      end

      ulc_pkg::S_IDLE: begin
        ram_raddr = (in_op == ulc_pkg::OP_FETCH) ? cursor_q : in_word;
        if (in_acc) begin
          if (in_op == ulc_pkg::OP_FETCH) begin
            scan_d  = cursor_q;
            state_d = ulc_pkg::S_SCAN;
          end else if (in_mask) begin
            rec_word_d = in_word;
            rec_bit_d  = in_bit;
            if (in_word < cursor_q) begin
              cursor_d = in_word;
            end
            state_d = ulc_pkg::S_REC;
          end
        end
      end

      ulc_pkg::S_REC: begin
        ram_we    = 1'b1;
        ram_waddr = rec_word_q;
        state_d   = ulc_pkg::S_IDLE;
      end

      ulc_pkg::S_SCAN: begin
        if (wu_stat.nonzero) begin
          // Lowest present label: clear it and report
          if (slot_free) begin
            ram_we      = 1'b1;
            cursor_d    = scan_q;
            out_load    = 1'b1;
            out_label_d = 16'({scan_q, wu_stat.bit_idx});
            out_found_d = 1'b1;
            state_d     = ulc_pkg::S_IDLE;
          end
        end else if (&scan_q) begin
          // Store empty
          if (slot_free) begin
            ram_we      = 1'b1;
            cursor_d    = '0;
            out_load    = 1'b1;
            out_label_d = '0;
            out_found_d = 1'b0;
            state_d     = ulc_pkg::S_IDLE;
          end
        end else begin
          // Empty word: write back (drops an excluded background bit), move on
          ram_we    = 1'b1;
          scan_d    = scan_q + MAP_AW'(1);
          ram_raddr = scan_q + MAP_AW'(1);
        end
      end

      default: begin
        state_d = ulc_pkg::S_IDLE;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ulc_pkg::S_CLEAR;
      clr_q       <= '0;
      cursor_q    <= '0;
      incl_q      <= ulc_pkg::EXCL_BG;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cursor_q    <= cursor_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        incl_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    rec_word_q  <= rec_word_d;
    rec_bit_q   <= rec_bit_d;
    out_label_q <= out_label_d;
    out_found_q <= out_found_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_label_q;
  assign m_axis_tuser  = out_found_q;

  // Checks
  `ULC_ASSERT_NXT(a_fetch_scans, in_acc && (in_op == ulc_pkg::OP_FETCH), state_q == ulc_pkg::S_SCAN)
  `ULC_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_q || m_axis_tready)
  `ULC_ASSERT_IMP(a_cursor_le_scan, state_q == ulc_pkg::S_SCAN, cursor_q <= scan_q)
  `ULC_ASSERT_NXT(a_rec_writes, in_acc && (in_op == ulc_pkg::OP_RECORD) && in_mask, ram_we)

endmodule

`default_nettype wire
